// ===== design/sv39pw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39pw_pkg
// Shared types, field widths and codes for the Sv39 page table walker.
// ----------------------------------------------------------------------------
package sv39pw_pkg;

  localparam int VA_W    = 39;
  localparam int PTE_W   = 64;
  localparam int PPN_W   = 44;
  localparam int ADDR_W  = 56;
  localparam int MODE_W  = 4;
  localparam int VPN_W   = 9;
  localparam int OFS_W   = 12;
  localparam int CAUSE_W = 3;
  localparam int LEVEL_W = 2;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 64;

  localparam logic [MODE_W-1:0] MODE_BARE = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SV39 = 4'd8;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_ROOT = 1'b1;

  localparam logic [3:0] PTE_NODE_FLAGS = 4'h1;
  localparam logic [3:0] PTE_LEAF_FLAGS = 4'hF;

  localparam logic [LEVEL_W-1:0] LEVEL_ROOT = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd2;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_PTE_DATA  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_XLATE  = 2'd1,
    KIND_DIRECT = 2'd2,
    KIND_FAULT  = 2'd3
  } kind_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE = 3'd0,
    CAUSE_MODE = 3'd1,
    CAUSE_L1   = 3'd2,
    CAUSE_L2   = 3'd3,
    CAUSE_LEAF = 3'd4
  } cause_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    cause_t            cause;
  } result_t;

endpackage

// ===== design/sv39_page_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_page_walker
// Sv39 page table walker: translate requests and returned page table entries
// come in on one stream, read requests, translations and faults go out.
// ----------------------------------------------------------------------------
// Path: an accepted input transaction is held in the input register, then
//   its result is registered in the result register and shows on out_tvalid.
// Throughput: one transaction per cycle; the input register and the result
//   register advance together whenever the result register is free or taken.
// Reset: rst_n (synchronous, active low) empties both registers, ends any
//   walk and clears translation_mode and root_table_ppn to zero.
// ----------------------------------------------------------------------------
module sv39_page_walker (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [sv39pw_pkg::PPN_W-1:0]      cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: [38:0] virtual_address, [102:39] entry_data, [103] zero
  input  logic [sv39pw_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: [0] operation
  input  logic                              in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: [55:0] address, [58:56] fault_cause, [63:59] zero
  output logic [sv39pw_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: [1:0] result_kind
  output logic [1:0]                        out_tuser
);
  import sv39pw_pkg::*;

  // configuration registers
  logic [MODE_W-1:0] mode_r;
  logic [PPN_W-1:0]  root_r;

  // input register
  logic             in_v_r;
  op_t              op_r;
  logic [VA_W-1:0]  va_r;
  logic [PTE_W-1:0] pte_r;

  // result register
  logic              out_v_r;
  kind_t             kind_r;
  logic [ADDR_W-1:0] addr_r;
  cause_t            cause_r;

  logic    advance;
  logic    out_free;
  result_t res;

  // Advance the held transaction when the result slot is free or being taken.
  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && out_free;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BARE;
      root_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
        CFG_ROOT: root_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // Capture a new transaction; drop the held one once it has advanced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= op_t'(in_tuser);
      va_r  <= in_tdata[VA_W-1:0];
      pte_r <= in_tdata[VA_W+PTE_W-1:VA_W];
    end
  end

  // Walk state and the per-item decision; state moves only on advance.
  sv39pw_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (advance),
    .item_op   (op_r),
    .item_va   (va_r),
    .item_pte  (pte_r),
    .mode      (mode_r),
    .root_ppn  (root_r),
    .res       (res)
  );

  // Hold the result until taken; items that cause no result leave a bubble.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      kind_r  <= res.kind;
      addr_r  <= res.address;
      cause_r <= res.cause;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {{(OUT_DATA_W-ADDR_W-CAUSE_W){1'b0}}, cause_r, addr_r};

endmodule

// ===== design/sv39pw_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39pw_walk
// Walk state and combinational decision logic for one item.
// ----------------------------------------------------------------------------
module sv39pw_walk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_fire,
  input  sv39pw_pkg::op_t               item_op,
  input  logic [sv39pw_pkg::VA_W-1:0]   item_va,
  input  logic [sv39pw_pkg::PTE_W-1:0]  item_pte,
  input  logic [sv39pw_pkg::MODE_W-1:0] mode,
  input  logic [sv39pw_pkg::PPN_W-1:0]  root_ppn,
  output sv39pw_pkg::result_t           res
);
  import sv39pw_pkg::*;

  logic               active_r, active_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [VA_W-1:0]    vaddr_r, vaddr_nxt;

  logic [PPN_W-1:0] pte_ppn;
  logic             pte_top;
  logic [VPN_W-1:0] next_vpn;

  assign pte_ppn = item_pte[53:10];
  assign pte_top = item_pte[63];

  // index for the level after the current one
  always_comb begin
    case (level_r)
      LEVEL_ROOT: next_vpn = vaddr_r[29:21];
      default:    next_vpn = vaddr_r[20:12];
    endcase
  end

  always_comb begin
    active_nxt  = active_r;
    level_nxt   = level_r;
    vaddr_nxt   = vaddr_r;
    res.valid   = 1'b0;
    res.kind    = KIND_READ;
    res.address = '0;
    res.cause   = CAUSE_NONE;
    if (item_fire) begin
      if (item_op == OP_TRANSLATE) begin
        if (!active_r) begin
          res.valid = 1'b1;
          if (mode == MODE_BARE) begin
            res.kind    = KIND_DIRECT;
            res.address = {{(ADDR_W-VA_W){1'b0}}, item_va};
          end else if (mode != MODE_SV39) begin
            res.kind  = KIND_FAULT;
            res.cause = CAUSE_MODE;
          end else begin
            active_nxt  = 1'b1;
            level_nxt   = LEVEL_ROOT;
            vaddr_nxt   = item_va;
            // base low bits are zero, so base + vpn*8 is a concatenation
            res.address = {root_ppn, item_va[38:30], 3'b000};
          end
        end
      end else if (active_r) begin
        res.valid = 1'b1;
        if (level_r == LEVEL_ROOT || level_r == LEVEL_MID) begin
          if (item_pte[3:0] == PTE_NODE_FLAGS && pte_top) begin
            level_nxt   = level_r + 2'd1;
            res.address = {pte_ppn, next_vpn, 3'b000};
          end else begin
            active_nxt = 1'b0;
            res.kind   = KIND_FAULT;
            res.cause  = (level_r == LEVEL_ROOT) ? CAUSE_L1 : CAUSE_L2;
          end
        end else begin
          // any other level value acts as the leaf
          active_nxt = 1'b0;
          if (item_pte[3:0] == PTE_LEAF_FLAGS && pte_top) begin
            res.kind    = KIND_XLATE;
            res.address = {pte_ppn, vaddr_r[OFS_W-1:0]};
          end else begin
            res.kind  = KIND_FAULT;
            res.cause = CAUSE_LEAF;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      level_r  <= LEVEL_ROOT;
      vaddr_r  <= '0;
    end else begin
      active_r <= active_nxt;
      level_r  <= level_nxt;
      vaddr_r  <= vaddr_nxt;
    end
  end

endmodule
